FILE: hdl/ics_pkg.sv
// Shared constants and types for the input completeness scanner.
`timescale 1ns / 1ps

package ics_pkg;

    localparam int DEPTH_BITS = 8;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    localparam logic ACT_FEED  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef logic [DEPTH_BITS-1:0] depth_t;

    typedef struct packed {
        depth_t paren_depth;
        depth_t bracket_depth;
        depth_t brace_count;
        logic   bar_open;
        logic   string_open;
        logic   escape_pending;
        logic   line_comment_open;
        logic   block_comment_open;
        logic   slash_pending;
        logic   star_pending;
        logic   overflow_seen;
    } scan_state_t;

    typedef struct packed {
        logic complete;
        logic inside_string;
        logic inside_comment;
        logic depth_overflow;
    } scan_result_t;

    localparam scan_state_t SCAN_STATE_CLEAR = '0;

endpackage

FILE: hdl/ics_step.sv
// Next-state and result logic for one scanned item.
`timescale 1ns / 1ps

module ics_step (
    input  logic                action,
    input  logic [7:0]          char_byte,
    input  ics_pkg::scan_state_t cur_state,
    output ics_pkg::scan_state_t new_state,
    output ics_pkg::scan_result_t result
);
    import ics_pkg::*;

    scan_state_t s;
    logic        normal;

    always_comb
    begin
        s      = cur_state;
        normal = 1'b0;
        if (action == ACT_CLEAR)
        begin
            s = SCAN_STATE_CLEAR;
        end
        else if (cur_state.line_comment_open)
        begin
            if (char_byte == CH_NL)
                s.line_comment_open = 1'b0;
        end
        else if (cur_state.block_comment_open)
        begin
            s.star_pending = 1'b0;
            if (cur_state.star_pending && char_byte == CH_SLASH)
                s.block_comment_open = 1'b0;
            else if (char_byte == CH_STAR)
                s.star_pending = 1'b1;
        end
        else if (cur_state.string_open)
        begin
            if (cur_state.escape_pending)
                s.escape_pending = 1'b0;
            else if (char_byte == CH_BSLASH)
                s.escape_pending = 1'b1;
            else if (char_byte == CH_QUOTE)
                s.string_open = 1'b0;
        end
        else
        begin
            s.slash_pending = 1'b0;
            // slash-star opens a block comment and eats the star
            if (cur_state.slash_pending && char_byte == CH_STAR)
            begin
                s.block_comment_open = 1'b1;
                s.star_pending       = 1'b0;
            end
            else
            begin
                normal = 1'b1;
            end
        end

        if (normal)
        begin
            case (char_byte)
                CH_BSLASH: s.line_comment_open = 1'b1;
                CH_SLASH:  s.slash_pending = 1'b1;
                CH_LPAREN:
                begin
                    if (cur_state.paren_depth == DEPTH_MAX)
                        s.overflow_seen = 1'b1;
                    else
                        s.paren_depth = cur_state.paren_depth + depth_t'(1);
                end
                CH_RPAREN:
                begin
                    if (cur_state.paren_depth != '0)
                        s.paren_depth = cur_state.paren_depth - depth_t'(1);
                end
                CH_QUOTE:
                begin
                    s.string_open    = 1'b1;
                    s.escape_pending = 1'b0;
                end
                CH_LBRACK:
                begin
                    if (cur_state.bracket_depth == DEPTH_MAX)
                        s.overflow_seen = 1'b1;
                    else
                        s.bracket_depth = cur_state.bracket_depth + depth_t'(1);
                end
                CH_RBRACK:
                begin
                    if (cur_state.bracket_depth != '0)
                        s.bracket_depth = cur_state.bracket_depth - depth_t'(1);
                end
                CH_LBRACE:
                begin
                    if (cur_state.brace_count == DEPTH_MAX)
                        s.overflow_seen = 1'b1;
                    else
                        s.brace_count = cur_state.brace_count + depth_t'(1);
                end
                CH_RBRACE:
                begin
                    if (cur_state.brace_count != '0)
                        s.brace_count = cur_state.brace_count - depth_t'(1);
                end
                CH_BAR:    s.bar_open = ~cur_state.bar_open;
                default:   ;
            endcase
        end
    end

    assign new_state = s;

    assign result.complete = !s.string_open && !s.escape_pending && !s.line_comment_open &&
                             !s.block_comment_open && s.paren_depth == '0 &&
                             s.bracket_depth == '0 && s.brace_count == '0 && !s.bar_open;
    assign result.inside_string  = s.string_open;
    assign result.inside_comment = s.line_comment_open || s.block_comment_open;
    assign result.depth_overflow = s.overflow_seen;

endmodule

FILE: hdl/input_completeness_scanner.sv
// Top level of the input completeness scanner: input register, scan state, result register.
// out_valid rises once the item has moved from the input register into the result register.
// Throughput: one item per cycle while out_stall is low; the scan state loop runs via state_reg.
// in_stall rises only while the result register holds an item and out_stall is high.
// Reset (rst_n low, asynchronous) clears the scan state and both valid flags.
// A clear action returns the scan state to its reset value.
`timescale 1ns / 1ps

module input_completeness_scanner (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] char_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       complete,
    output logic       inside_string,
    output logic       inside_comment,
    output logic       depth_overflow
);
    import ics_pkg::*;

    logic         in_valid_reg;
    logic         action_reg;
    logic [7:0]   char_reg;
    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t result_next;
    scan_result_t result_reg;
    logic         out_valid_reg;

    logic out_load;
    logic in_load;
    logic step_fire;

    assign out_load  = !out_valid_reg || !out_stall;
    assign in_load   = !in_valid_reg || out_load;
    assign step_fire = in_valid_reg && out_load;
    assign in_stall  = !in_load;

    ics_step u_step (
        .action    (action_reg),
        .char_byte (char_reg),
        .cur_state (state_reg),
        .new_state (state_next),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= SCAN_STATE_CLEAR;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
            if (step_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            action_reg <= action;
            char_reg   <= char_byte;
        end
        if (step_fire)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign complete       = result_reg.complete;
    assign inside_string  = result_reg.inside_string;
    assign inside_comment = result_reg.inside_comment;
    assign depth_overflow = result_reg.depth_overflow;

    a_escape_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.escape_pending |-> state_reg.string_open)
        else $error("escape pending outside a string");

    a_star_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.star_pending |-> state_reg.block_comment_open)
        else $error("star pending outside a block comment");

    a_slash_plain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.slash_pending |-> !state_reg.string_open &&
            !state_reg.line_comment_open && !state_reg.block_comment_open)
        else $error("slash pending inside a string or comment");

    a_complete_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.complete |-> !result_reg.inside_string &&
            !result_reg.inside_comment)
        else $error("complete reported with a string or comment open");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && action_reg == ACT_FEED && state_reg.overflow_seen
            |=> state_reg.overflow_seen)
        else $error("overflow flag dropped without a clear");

endmodule
